// File: design/semiglobal_alignment_unit_assert.svh
// Assertion macros for the semiglobal alignment unit.
`ifndef SEMIGLOBAL_ALIGNMENT_UNIT_ASSERT_SVH
`define SEMIGLOBAL_ALIGNMENT_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SGA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SGA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/sga_pkg.sv
// Shared types and constants of the semiglobal alignment unit.
`default_nettype none
package sga_pkg;

  localparam int SYM_W   = 8;
  localparam int SCORE_W = 7;
  localparam int POS_W   = 6;
  localparam int ERR_W   = 7;

  typedef logic signed [SCORE_W-1:0] score_t;

  typedef enum logic [1:0] {
    OP_LOAD_FIRST  = 2'd0,
    OP_LOAD_SECOND = 2'd1,
    OP_RUN         = 2'd2
  } opcode_t;

  // traceback pointer kept per matrix cell
  typedef enum logic [1:0] {
    DIR_LEFT = 2'd1,
    DIR_UP   = 2'd2,
    DIR_DIAG = 2'd3
  } dir_t;

  // word moving down the cell chain
  typedef struct packed {
    logic               valid;
    logic [SYM_W-1:0]   sym;
    score_t             score;
  } flow_t;

  // one alignment column
  typedef struct packed {
    logic [SYM_W-1:0] top_char;
    logic             top_gap;
    logic [SYM_W-1:0] bot_char;
    logic             bot_gap;
  } col_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FEED,
    ST_DRAIN,
    ST_SCAN,
    ST_TB_RD,
    ST_TB_EX,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    PH_END_T,
    PH_END_B,
    PH_CORE,
    PH_TAIL_T,
    PH_TAIL_B
  } phase_t;

  typedef enum logic [1:0] {
    K_TOP_GAP,
    K_BOT_GAP,
    K_CORE
  } kind_t;

endpackage
`default_nettype wire

// File: design/sga_cell.sv
// One row cell of the score chain: a first-string symbol, its running score and row pointers.
`default_nettype none
module sga_cell #(
  parameter int IDX_W = 5
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     clr,
  input  wire logic                     load_en,
  input  wire logic [sga_pkg::SYM_W-1:0] load_sym,
  input  wire sga_pkg::flow_t           in_word,
  input  wire logic [IDX_W-1:0]         in_col,
  output sga_pkg::flow_t                out_word_r,
  output logic [IDX_W-1:0]              out_col_r,
  input  wire logic [IDX_W-1:0]         rd_addr,
  output sga_pkg::dir_t                 dir_r,
  output logic [sga_pkg::SYM_W-1:0]     sym_a_r,
  output sga_pkg::score_t               score_r
);

  localparam int DEPTH = 1 << IDX_W;

  sga_pkg::score_t diag_r;
  sga_pkg::dir_t   dmem [DEPTH];

  sga_pkg::score_t bonus, s_diag, s_up, s_left, s1, s_new;
  sga_pkg::dir_t   d1, d_new;

  // cell update: diagonal first, then up, then left on strict gain
  always_comb begin
    bonus  = (sym_a_r == in_word.sym) ? sga_pkg::score_t'(1) : sga_pkg::score_t'(-1);
    s_diag = diag_r + bonus;
    s_up   = in_word.score - sga_pkg::score_t'(1);
    s_left = score_r - sga_pkg::score_t'(1);
    if (s_up > s_diag) begin
      s1 = s_up;
      d1 = sga_pkg::DIR_UP;
    end else begin
      s1 = s_diag;
      d1 = sga_pkg::DIR_DIAG;
    end
    if (s_left > s1) begin
      s_new = s_left;
      d_new = sga_pkg::DIR_LEFT;
    end else begin
      s_new = s1;
      d_new = d1;
    end
  end

  // handshake bit toward the next cell, scores, forwarded symbol and pointer store
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      out_word_r.valid <= 1'b0;
    end else begin
      out_word_r.valid <= in_word.valid;
    end
    if (clr) begin
      score_r <= '0;
      diag_r  <= '0;
    end else if (in_word.valid) begin
      score_r          <= s_new;
      diag_r           <= in_word.score;
      dmem[in_col]     <= d_new;
      out_word_r.sym   <= in_word.sym;
      out_word_r.score <= s_new;
      out_col_r        <= in_col;
    end
    if (load_en) begin
      sym_a_r <= load_sym;
    end
    dir_r <= dmem[rd_addr];
  end

endmodule
`default_nettype wire

// File: design/semiglobal_alignment_unit.sv
// Top level of the semiglobal aligner: loaders, cell chain, best-cell search,
// traceback and column output.
//
// Command channel: a word is taken at a clock edge with start high and busy low.
// in_opcode selects: append in_symbol to the first string, append it to the
// second string, or run the alignment. Appends leave busy low,
// and a symbol past MAX_LEN is dropped and flagged in out_truncated.
// A run raises busy. The second string streams into a chain of MAX_LEN row
// cells, one column per cycle. The last row is watched
// as it leaves the chain, then the last column is scanned.
// Traceback alternates a pointer read state and a column push state per alignment column,
// bounded by the single read port of each cell's pointer store.
// Columns then come out in forward order, one per cycle, each on the out_
// ports for one cycle with out_valid high; out_last marks the final one. The
// receiver cannot stall. Both strings are empty again after a run.
// Empty strings give one word with out_has_column low.
// Reset clears both counts, the flag and the sequencer; stores are not cleared.
`default_nettype none
module semiglobal_alignment_unit #(
  parameter int MAX_LEN = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   in_opcode,
  input  wire logic [sga_pkg::SYM_W-1:0]    in_symbol,
  output logic                              out_valid,
  output logic [sga_pkg::SYM_W-1:0]         out_top_char,
  output logic                              out_top_gap,
  output logic [sga_pkg::SYM_W-1:0]         out_bottom_char,
  output logic                              out_bottom_gap,
  output logic [sga_pkg::POS_W-1:0]         out_start_first,
  output logic [sga_pkg::POS_W-1:0]         out_stop_first,
  output logic [sga_pkg::POS_W-1:0]         out_start_second,
  output logic [sga_pkg::POS_W-1:0]         out_stop_second,
  output logic [sga_pkg::ERR_W-1:0]         out_error_count,
  output logic                              out_last,
  output logic                              out_has_column,
  output logic                              out_truncated
);

  localparam int IDX_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CNT_W  = $clog2(MAX_LEN + 1);
  localparam int RV_D   = 2 * MAX_LEN;
  localparam int RV_IW  = $clog2(RV_D);
  localparam int RVC_W  = $clog2(RV_D + 1);
  localparam int DR_END = MAX_LEN + 3;
  localparam int DR_W   = $clog2(DR_END + 1);

  // ---------------- registers ----------------
  sga_pkg::state_t state_r, state_nxt;
  sga_pkg::phase_t phase_r, phase_nxt;
  sga_pkg::kind_t  kind_r, kind_nxt;
  logic [CNT_W-1:0] first_cnt_r, first_cnt_nxt, second_cnt_r, second_cnt_nxt;
  logic             ovf_r, ovf_nxt, run_ovf_r, run_ovf_nxt;
  logic [CNT_W-1:0] feed_addr_r, feed_addr_nxt;
  logic             feed_valid_r;
  logic [IDX_W-1:0] feed_col_r;
  logic [DR_W-1:0]  drain_r, drain_nxt;
  sga_pkg::score_t  best_r, best_nxt;
  logic [CNT_W-1:0] bi_r, bi_nxt, bj_r, bj_nxt, scan_r, scan_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt, start1_r, start1_nxt, start2_r, start2_nxt;
  logic [sga_pkg::ERR_W-1:0] err_r, err_nxt;
  logic [RVC_W-1:0] rv_len_r, rv_len_nxt, rem_r, rem_nxt;
  logic [RV_IW-1:0] ptr_r, ptr_nxt;
  logic             hc_r, hc_nxt, out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;

  // ---------------- memories ----------------
  logic [sga_pkg::SYM_W-1:0] smem [MAX_LEN];
  logic [sga_pkg::SYM_W-1:0] smem_rd_r;
  sga_pkg::col_t             rvmem [RV_D];
  sga_pkg::col_t             rv_rd_r;

  // ---------------- controls ----------------
  logic             accept, cell_clr, load_first_en, smem_we, rv_we, feed_issue;
  logic [IDX_W-1:0] smem_ra, jm1;
  sga_pkg::col_t    rv_wdata;
  sga_pkg::score_t  scan_val;
  logic [CNT_W-1:0] tap_col;

  // ---------------- cell chain ----------------
  sga_pkg::flow_t            link [MAX_LEN+1];
  logic [IDX_W-1:0]          col_link [MAX_LEN+1];
  sga_pkg::score_t           sc_arr [MAX_LEN+1];
  logic [sga_pkg::SYM_W-1:0] a_arr [MAX_LEN+1];
  sga_pkg::dir_t             dir_arr [MAX_LEN+1];

  assign link[0].valid = feed_valid_r;
  assign link[0].sym   = smem_rd_r;
  assign link[0].score = '0;
  assign col_link[0]   = feed_col_r;
  assign sc_arr[0]     = '0;
  assign a_arr[0]      = '0;
  assign dir_arr[0]    = sga_pkg::DIR_DIAG;

  for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
    sga_cell #(.IDX_W(IDX_W)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .clr        (cell_clr),
      .load_en    (load_first_en && (first_cnt_r == CNT_W'(g))),
      .load_sym   (in_symbol),
      .in_word    (link[g]),
      .in_col     (col_link[g]),
      .out_word_r (link[g+1]),
      .out_col_r  (col_link[g+1]),
      .rd_addr    (jm1),
      .dir_r      (dir_arr[g+1]),
      .sym_a_r    (a_arr[g+1]),
      .score_r    (sc_arr[g+1])
    );
  end

  assign accept   = start && (state_r == sga_pkg::ST_IDLE);
  assign busy     = (state_r != sga_pkg::ST_IDLE);
  assign jm1      = IDX_W'(j_r - CNT_W'(1));
  assign scan_val = sc_arr[scan_r];
  assign tap_col  = CNT_W'(col_link[first_cnt_r]) + CNT_W'(1);

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    kind_nxt       = kind_r;
    first_cnt_nxt  = first_cnt_r;
    second_cnt_nxt = second_cnt_r;
    ovf_nxt        = ovf_r;
    run_ovf_nxt    = run_ovf_r;
    feed_addr_nxt  = feed_addr_r;
    drain_nxt      = drain_r;
    best_nxt       = best_r;
    bi_nxt         = bi_r;
    bj_nxt         = bj_r;
    scan_nxt       = scan_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    start1_nxt     = start1_r;
    start2_nxt     = start2_r;
    err_nxt        = err_r;
    rv_len_nxt     = rv_len_r;
    rem_nxt        = rem_r;
    ptr_nxt        = ptr_r;
    hc_nxt         = hc_r;
    out_valid_nxt  = 1'b0;
    out_last_nxt   = 1'b0;
    cell_clr       = 1'b0;
    load_first_en  = 1'b0;
    smem_we        = 1'b0;
    rv_we          = 1'b0;
    rv_wdata       = '0;
    feed_issue     = 1'b0;
    smem_ra        = jm1;

    unique case (state_r)
      sga_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_opcode)
            sga_pkg::OP_LOAD_FIRST: begin
              if (first_cnt_r < CNT_W'(MAX_LEN)) begin
                load_first_en = 1'b1;
                first_cnt_nxt = first_cnt_r + CNT_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            sga_pkg::OP_LOAD_SECOND: begin
              if (second_cnt_r < CNT_W'(MAX_LEN)) begin
                smem_we        = 1'b1;
                second_cnt_nxt = second_cnt_r + CNT_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
            sga_pkg::OP_RUN: begin
              cell_clr      = 1'b1;
              run_ovf_nxt   = ovf_r;
              ovf_nxt       = 1'b0;
              best_nxt      = '0;
              bi_nxt        = first_cnt_r;
              bj_nxt        = '0;
              feed_addr_nxt = '0;
              state_nxt     = sga_pkg::ST_FEED;
            end
            default: ;
          endcase
        end
      end

      sga_pkg::ST_FEED, sga_pkg::ST_DRAIN: begin
        // last row streams out of cell m-1
        if (first_cnt_r != '0 && link[first_cnt_r].valid &&
            link[first_cnt_r].score >= best_r) begin
          best_nxt = link[first_cnt_r].score;
          bj_nxt   = tap_col;
        end
        if (state_r == sga_pkg::ST_FEED) begin
          smem_ra = IDX_W'(feed_addr_r);
          if (feed_addr_r < second_cnt_r) begin
            feed_issue    = 1'b1;
            feed_addr_nxt = feed_addr_r + CNT_W'(1);
          end else begin
            drain_nxt = '0;
            state_nxt = sga_pkg::ST_DRAIN;
          end
        end else begin
          drain_nxt = drain_r + DR_W'(1);
          if (drain_r == DR_W'(DR_END)) begin
            scan_nxt  = '0;
            state_nxt = sga_pkg::ST_SCAN;
          end
        end
      end

      sga_pkg::ST_SCAN: begin
        // last column, later equal score wins
        if (scan_val >= best_r) begin
          best_nxt = scan_val;
          bi_nxt   = scan_r;
          bj_nxt   = second_cnt_r;
        end
        scan_nxt = scan_r + CNT_W'(1);
        if (scan_r == first_cnt_r) begin
          i_nxt      = first_cnt_r;
          j_nxt      = second_cnt_r;
          err_nxt    = '0;
          rv_len_nxt = '0;
          phase_nxt  = (first_cnt_r == bi_nxt) ? sga_pkg::PH_END_T : sga_pkg::PH_END_B;
          state_nxt  = sga_pkg::ST_TB_RD;
        end
      end

      sga_pkg::ST_TB_RD: begin
        // pick the next column kind; reads of j-1 are issued this cycle
        unique case (phase_r)
          sga_pkg::PH_END_T: begin
            if (j_r > bj_r) begin
              kind_nxt  = sga_pkg::K_TOP_GAP;
              state_nxt = sga_pkg::ST_TB_EX;
            end else begin
              phase_nxt = sga_pkg::PH_CORE;
            end
          end
          sga_pkg::PH_END_B: begin
            if (i_r > bi_r) begin
              kind_nxt  = sga_pkg::K_BOT_GAP;
              state_nxt = sga_pkg::ST_TB_EX;
            end else begin
              phase_nxt = sga_pkg::PH_CORE;
            end
          end
          sga_pkg::PH_CORE: begin
            if (i_r != '0 && j_r != '0) begin
              kind_nxt  = sga_pkg::K_CORE;
              state_nxt = sga_pkg::ST_TB_EX;
            end else begin
              start1_nxt = i_r;
              start2_nxt = j_r;
              phase_nxt  = sga_pkg::PH_TAIL_T;
            end
          end
          sga_pkg::PH_TAIL_T: begin
            if (j_r != '0) begin
              kind_nxt  = sga_pkg::K_TOP_GAP;
              state_nxt = sga_pkg::ST_TB_EX;
            end else begin
              phase_nxt = sga_pkg::PH_TAIL_B;
            end
          end
          sga_pkg::PH_TAIL_B: begin
            if (i_r != '0) begin
              kind_nxt  = sga_pkg::K_BOT_GAP;
              state_nxt = sga_pkg::ST_TB_EX;
            end else begin
              ptr_nxt   = RV_IW'(rv_len_r - RVC_W'(1));
              rem_nxt   = (rv_len_r == '0) ? RVC_W'(1) : rv_len_r;
              hc_nxt    = (rv_len_r != '0);
              state_nxt = sga_pkg::ST_EMIT;
            end
          end
          default: state_nxt = sga_pkg::ST_IDLE;
        endcase
      end

      sga_pkg::ST_TB_EX: begin
        // push one column in reverse order
        rv_we     = 1'b1;
        state_nxt = sga_pkg::ST_TB_RD;
        unique case (kind_r)
          sga_pkg::K_TOP_GAP: begin
            rv_wdata = '{top_char: '0, top_gap: 1'b1, bot_char: smem_rd_r, bot_gap: 1'b0};
            j_nxt    = j_r - CNT_W'(1);
          end
          sga_pkg::K_BOT_GAP: begin
            rv_wdata = '{top_char: a_arr[i_r], top_gap: 1'b0, bot_char: '0, bot_gap: 1'b1};
            i_nxt    = i_r - CNT_W'(1);
          end
          sga_pkg::K_CORE: begin
            unique case (dir_arr[i_r])
              sga_pkg::DIR_DIAG: begin
                rv_wdata = '{top_char: a_arr[i_r], top_gap: 1'b0,
                             bot_char: smem_rd_r, bot_gap: 1'b0};
                i_nxt    = i_r - CNT_W'(1);
                j_nxt    = j_r - CNT_W'(1);
                if (a_arr[i_r] != smem_rd_r) begin
                  err_nxt = err_r + sga_pkg::ERR_W'(1);
                end
              end
              sga_pkg::DIR_LEFT: begin
                rv_wdata = '{top_char: '0, top_gap: 1'b1, bot_char: smem_rd_r, bot_gap: 1'b0};
                j_nxt    = j_r - CNT_W'(1);
                err_nxt  = err_r + sga_pkg::ERR_W'(1);
              end
              default: begin
                rv_wdata = '{top_char: a_arr[i_r], top_gap: 1'b0, bot_char: '0, bot_gap: 1'b1};
                i_nxt    = i_r - CNT_W'(1);
                err_nxt  = err_r + sga_pkg::ERR_W'(1);
              end
            endcase
          end
          default: rv_we = 1'b0;
        endcase
        if (rv_we) begin
          rv_len_nxt = rv_len_r + RVC_W'(1);
        end
      end

      sga_pkg::ST_EMIT: begin
        // one column word per cycle; the buffer read and the strobe are registered together
        out_valid_nxt = 1'b1;
        out_last_nxt  = (rem_r == RVC_W'(1));
        ptr_nxt       = ptr_r - RV_IW'(1);
        rem_nxt       = rem_r - RVC_W'(1);
        if (rem_r == RVC_W'(1)) begin
          first_cnt_nxt  = '0;
          second_cnt_nxt = '0;
          state_nxt      = sga_pkg::ST_IDLE;
        end
      end

      default: state_nxt = sga_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sga_pkg::ST_IDLE;
      first_cnt_r  <= '0;
      second_cnt_r <= '0;
      ovf_r        <= 1'b0;
      feed_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      first_cnt_r  <= first_cnt_nxt;
      second_cnt_r <= second_cnt_nxt;
      ovf_r        <= ovf_nxt;
      feed_valid_r <= feed_issue;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    phase_r     <= phase_nxt;
    kind_r      <= kind_nxt;
    run_ovf_r   <= run_ovf_nxt;
    feed_addr_r <= feed_addr_nxt;
    feed_col_r  <= IDX_W'(feed_addr_r);
    drain_r     <= drain_nxt;
    best_r      <= best_nxt;
    bi_r        <= bi_nxt;
    bj_r        <= bj_nxt;
    scan_r      <= scan_nxt;
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    start1_r    <= start1_nxt;
    start2_r    <= start2_nxt;
    err_r       <= err_nxt;
    rv_len_r    <= rv_len_nxt;
    rem_r       <= rem_nxt;
    ptr_r       <= ptr_nxt;
    hc_r        <= hc_nxt;
    out_last_r  <= out_last_nxt;
  end

  // second-string store
  always_ff @(posedge clk) begin
    if (smem_we) begin
      smem[IDX_W'(second_cnt_r)] <= in_symbol;
    end
    smem_rd_r <= smem[smem_ra];
  end

  // reversed column buffer
  always_ff @(posedge clk) begin
    if (rv_we) begin
      rvmem[RV_IW'(rv_len_r)] <= rv_wdata;
    end
    rv_rd_r <= rvmem[ptr_r];
  end

  // ---------------- result ports ----------------
  assign out_valid        = out_valid_r;
  assign out_top_char     = hc_r ? rv_rd_r.top_char : '0;
  assign out_top_gap      = hc_r && rv_rd_r.top_gap;
  assign out_bottom_char  = hc_r ? rv_rd_r.bot_char : '0;
  assign out_bottom_gap   = hc_r && rv_rd_r.bot_gap;
  assign out_start_first  = sga_pkg::POS_W'(start1_r);
  assign out_stop_first   = sga_pkg::POS_W'(bi_r);
  assign out_start_second = sga_pkg::POS_W'(start2_r);
  assign out_stop_second  = sga_pkg::POS_W'(bj_r);
  assign out_error_count  = err_r;
  assign out_last         = out_last_r;
  assign out_has_column   = hc_r;
  assign out_truncated    = run_ovf_r;

  // ---------------- assertions ----------------
`include "semiglobal_alignment_unit_assert.svh"
  `SGA_ASSERT_IMP(a_last_frees, out_valid_r && out_last_r, !busy)
  `SGA_ASSERT_IMP(a_word_from_emit, out_valid_r, $past(state_r == sga_pkg::ST_EMIT))
  `SGA_ASSERT_NXT(a_run_busy, accept && (in_opcode == sga_pkg::OP_RUN), busy)
  `SGA_ASSERT_IMP(a_empty_single, out_valid_r && !hc_r, out_last_r)

endmodule
`default_nettype wire

// File: test/semiglobal_alignment_checker.sv
// Checker for the semiglobal alignment unit: predicts the columns of each run and compares.
`timescale 1ns / 100ps
`default_nettype none
module semiglobal_alignment_checker
  import sga_pkg::*;
#(
  parameter int MAX_LEN = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic                busy,
  input  wire logic [1:0]          in_opcode,
  input  wire logic [SYM_W-1:0]    in_symbol,
  input  wire logic                out_valid,
  input  wire logic [SYM_W-1:0]    out_top_char,
  input  wire logic                out_top_gap,
  input  wire logic [SYM_W-1:0]    out_bottom_char,
  input  wire logic                out_bottom_gap,
  input  wire logic [POS_W-1:0]    out_start_first,
  input  wire logic [POS_W-1:0]    out_stop_first,
  input  wire logic [POS_W-1:0]    out_start_second,
  input  wire logic [POS_W-1:0]    out_stop_second,
  input  wire logic [ERR_W-1:0]    out_error_count,
  input  wire logic                out_last,
  input  wire logic                out_has_column,
  input  wire logic                out_truncated,
  output int                       fail_count,
  output int                       pending_words
);

  // one expected result word
  typedef struct {
    logic [SYM_W-1:0] top_char;
    logic             top_gap;
    logic [SYM_W-1:0] bot_char;
    logic             bot_gap;
    logic [POS_W-1:0] start_first;
    logic [POS_W-1:0] stop_first;
    logic [POS_W-1:0] start_second;
    logic [POS_W-1:0] stop_second;
    logic [ERR_W-1:0] errors;
    logic             last;
    logic             has_column;
    logic             truncated;
  } column_word_t;

  logic [SYM_W-1:0] first_str [MAX_LEN];
  logic [SYM_W-1:0] second_str [MAX_LEN];
  int               first_len;
  int               second_len;
  logic             dropped;
  int               line_score [MAX_LEN+1];
  dir_t             pointer [MAX_LEN*MAX_LEN];
  column_word_t     expected_columns [$];
  column_word_t     traced [$];

  // add one traced column, gap side zeroed
  function automatic void trace_col(logic [SYM_W-1:0] t, logic tg,
                                    logic [SYM_W-1:0] b, logic bg);
    column_word_t c;
    c = '{default: '0};
    c.top_char = tg ? '0 : t;
    c.top_gap  = tg;
    c.bot_char = bg ? '0 : b;
    c.bot_gap  = bg;
    traced.push_back(c);
  endfunction

  // fill the matrix, pick the best cell, trace back and queue the columns
  function automatic void predict_alignment();
    int m, n, i, j, bi, bj, best, errs, s, up, left, diag, st1, st2, cnt;
    int last_row [MAX_LEN+1];
    dir_t d;
    column_word_t w;
    m = first_len;
    n = second_len;
    for (i = 0; i <= m; i++) line_score[i] = 0;
    last_row[0] = 0;
    for (j = 1; j <= n; j++) begin
      diag = line_score[0];
      line_score[0] = 0;
      for (i = 1; i <= m; i++) begin
        up   = line_score[i-1];
        left = line_score[i];
        s = diag + ((first_str[i-1] == second_str[j-1]) ? 1 : -1);
        d = DIR_DIAG;
        if (up - 1 > s) begin
          d = DIR_UP;
          s = up - 1;
        end
        if (left - 1 > s) begin
          d = DIR_LEFT;
          s = left - 1;
        end
        diag = left;
        line_score[i] = s;
        pointer[(i-1)*MAX_LEN + (j-1)] = d;
      end
      last_row[j] = line_score[m];
    end
    // best cell: last row, then last column; later ties win
    best = -1; bi = m; bj = 0;
    for (j = 0; j <= n; j++)
      if (last_row[j] >= best) begin
        bi = m; bj = j; best = last_row[j];
      end
    for (i = 0; i <= m; i++)
      if (line_score[i] >= best) begin
        bi = i; bj = n; best = line_score[i];
      end
    traced.delete();
    i = m; j = n;
    if (i == bi) begin
      while (j > bj) begin
        j--; trace_col('0, 1'b1, second_str[j], 1'b0);
      end
    end else begin
      while (i > bi) begin
        i--; trace_col(first_str[i], 1'b0, '0, 1'b1);
      end
    end
    errs = 0;
    while (i > 0 && j > 0) begin
      d = pointer[(i-1)*MAX_LEN + (j-1)];
      if (d == DIR_DIAG) begin
        i--; j--;
        if (first_str[i] != second_str[j]) errs++;
        trace_col(first_str[i], 1'b0, second_str[j], 1'b0);
      end else if (d == DIR_LEFT) begin
        j--; errs++;
        trace_col('0, 1'b1, second_str[j], 1'b0);
      end else begin
        i--; errs++;
        trace_col(first_str[i], 1'b0, '0, 1'b1);
      end
    end
    st1 = i; st2 = j;
    while (j > 0) begin
      j--; trace_col('0, 1'b1, second_str[j], 1'b0);
    end
    while (i > 0) begin
      i--; trace_col(first_str[i], 1'b0, '0, 1'b1);
    end
    // queue in forward order
    cnt = (traced.size() == 0) ? 1 : traced.size();
    for (int k = 0; k < cnt; k++) begin
      if (traced.size() == 0) w = '{default: '0};
      else w = traced[traced.size() - 1 - k];
      w.start_first  = st1[POS_W-1:0];
      w.stop_first   = bi[POS_W-1:0];
      w.start_second = st2[POS_W-1:0];
      w.stop_second  = bj[POS_W-1:0];
      w.errors       = errs[ERR_W-1:0];
      w.last         = (k + 1 == cnt);
      w.has_column   = (traced.size() != 0);
      w.truncated    = dropped;
      expected_columns.push_back(w);
    end
    first_len  = 0;
    second_len = 0;
    dropped    = 1'b0;
  endfunction

  // unknown bits on the ports count as a mismatch
  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, exp, act);
      fail_count++;
    end
  endfunction

  initial begin
    fail_count    = 0;
    pending_words = 0;
  end

  // watch both channels at each edge
  always @(posedge clk) begin
    column_word_t e;
    if (!rst_n) begin
      first_len  = 0;
      second_len = 0;
      dropped    = 1'b0;
    end else begin
      // result side first: a word out now belongs to an earlier run
      if (out_valid) begin
        if (expected_columns.size() == 0) begin
          $display("%0t: result word with nothing expected", $time);
          fail_count++;
        end else begin
          e = expected_columns.pop_front();
          check_field("top_char", e.top_char, out_top_char);
          check_field("top_gap", e.top_gap, out_top_gap);
          check_field("bottom_char", e.bot_char, out_bottom_char);
          check_field("bottom_gap", e.bot_gap, out_bottom_gap);
          check_field("start_first", e.start_first, out_start_first);
          check_field("stop_first", e.stop_first, out_stop_first);
          check_field("start_second", e.start_second, out_start_second);
          check_field("stop_second", e.stop_second, out_stop_second);
          check_field("error_count", e.errors, out_error_count);
          check_field("last", e.last, out_last);
          check_field("has_column", e.has_column, out_has_column);
          check_field("truncated", e.truncated, out_truncated);
        end
      end
      if (start && !busy) begin
        case (in_opcode)
          OP_LOAD_FIRST: begin
            if (first_len < MAX_LEN) begin
              first_str[first_len] = in_symbol;
              first_len = first_len + 1;
            end else dropped = 1'b1;
          end
          OP_LOAD_SECOND: begin
            if (second_len < MAX_LEN) begin
              second_str[second_len] = in_symbol;
              second_len = second_len + 1;
            end else dropped = 1'b1;
          end
          OP_RUN: predict_alignment();
          default: ;
        endcase
      end
    end
    pending_words = expected_columns.size();
  end

endmodule
`default_nettype wire

// File: test/semiglobal_alignment_unit_test.sv
// Testbench top for the semiglobal alignment unit: stimulus, watchdog and verdict.
`timescale 1ns / 100ps
`default_nettype none
module semiglobal_alignment_unit_test;
  import sga_pkg::*;

  localparam int MAX_LEN = 32;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [1:0] in_opcode = OP_LOAD_FIRST;
  logic [SYM_W-1:0] in_symbol = '0;
  logic busy, out_valid, out_top_gap, out_bottom_gap, out_last, out_has_column, out_truncated;
  logic [SYM_W-1:0] out_top_char, out_bottom_char;
  logic [POS_W-1:0] out_start_first, out_stop_first, out_start_second, out_stop_second;
  logic [ERR_W-1:0] out_error_count;
  int fail_count, pending_words;
  int burst_left = 0;
  int words_sent = 0;
  int idle_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  semiglobal_alignment_unit #(.MAX_LEN(MAX_LEN)) u_dut (.*);

  semiglobal_alignment_checker #(.MAX_LEN(MAX_LEN)) u_checker (.*);

  // watchdog: stop when neither channel moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // send one command word; sender may idle between bursts
  task automatic send_word(logic [1:0] op, logic [SYM_W-1:0] sym);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
    end
    start     <= 1'b1;
    in_opcode <= op;
    in_symbol <= sym;
    do @(posedge clk); while (busy);
    burst_left--;
    if (op != OP_UNUSED) words_sent++;
  endtask

  // random symbol, mostly from a small alphabet so matches happen
  function automatic logic [SYM_W-1:0] pick_symbol(logic [SYM_W-1:0] base);
    if ($urandom_range(0, 9) < 7) return base + SYM_W'($urandom_range(0, 3));
    return SYM_W'($urandom);
  endfunction

  // load two strings of given length, interleaved, then run
  task automatic load_and_run(int len_a, int len_b, logic [SYM_W-1:0] base, bit noise);
    int a, b;
    a = 0; b = 0;
    while (a < len_a || b < len_b) begin
      if (noise && $urandom_range(0, 19) == 0) send_word(OP_UNUSED, SYM_W'($urandom));
      if (b >= len_b || (a < len_a && $urandom_range(0, 1) == 0)) begin
        send_word(OP_LOAD_FIRST, pick_symbol(base)); a++;
      end else begin
        send_word(OP_LOAD_SECOND, pick_symbol(base)); b++;
      end
    end
    send_word(OP_RUN, SYM_W'($urandom));
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 15) return $urandom_range(0, 10);
    if (r < 18) return $urandom_range(11, MAX_LEN);
    return $urandom_range(MAX_LEN - 1, MAX_LEN + 3);
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: both empty, one side empty, byte extremes, unused opcode
    send_word(OP_RUN, 8'h00);
    send_word(OP_LOAD_FIRST, 8'h00);
    send_word(OP_LOAD_FIRST, 8'hff);
    send_word(OP_RUN, 8'hff);
    send_word(OP_LOAD_SECOND, 8'hff);
    send_word(OP_LOAD_SECOND, 8'h00);
    send_word(OP_RUN, 8'h00);
    send_word(OP_UNUSED, 8'hff);
    send_word(OP_LOAD_FIRST, 8'hff);
    send_word(OP_LOAD_SECOND, 8'hff);
    send_word(OP_LOAD_FIRST, 8'h00);
    send_word(OP_LOAD_SECOND, 8'h5a);
    send_word(OP_RUN, 8'h00);
    // full first string plus one dropped symbol
    for (int k = 0; k <= MAX_LEN; k++) send_word(OP_LOAD_FIRST, SYM_W'(k));
    send_word(OP_LOAD_SECOND, 8'h07);
    send_word(OP_RUN, 8'h00);

    // random runs, mostly well-formed, some with noise and overflow
    while (words_sent < 330)
      load_and_run(pick_len(), pick_len(), SYM_W'($urandom), $urandom_range(0, 3) == 0);

    start <= 1'b0;
    // let the checker queue the last run before waiting on it
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_words == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
+incdir+design
design/sga_pkg.sv
design/sga_cell.sv
design/semiglobal_alignment_unit.sv
test/semiglobal_alignment_checker.sv
test/semiglobal_alignment_unit_test.sv
